[sv/wtli_pkg.sv]
package wtli_pkg;

   localparam int TABLE_DEPTH     = 1024;
   localparam int ADDR_BITS       = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS       = ADDR_BITS + 1;
   localparam int SAMPLE_BITS     = 16;
   localparam int PHASE_FRAC_BITS = 24;
   localparam int PHASE_BITS      = PHASE_FRAC_BITS + 1;
   localparam int INDEX_BITS      = 32;
   localparam int CNT_BITS        = $clog2(INDEX_BITS);
   localparam int DIFF_BITS       = SAMPLE_BITS + 1;

   // shared multiplier: signed operands wide enough for phase*size and frac*diff
   localparam int MUL_A_BITS      = PHASE_FRAC_BITS + 1;
   localparam int MUL_B_BITS      = (SIZE_BITS > DIFF_BITS ? SIZE_BITS : DIFF_BITS) + 1;
   localparam int PROD_BITS       = MUL_A_BITS + MUL_B_BITS;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_LOOP   = 2'd2;
   localparam logic [1:0] FUNC_INTERP = 2'd3;

   typedef struct packed {
      logic [1:0]                    func;
      logic [INDEX_BITS-1:0]         index;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [PHASE_BITS-1:0]         phase;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] value;
      logic                          error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOD,
      ST_RD,
      ST_RDW,
      ST_MUL1,
      ST_IDX,
      ST_RD0,
      ST_RD1,
      ST_DIFF,
      ST_MUL2,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

[sv/wavetable_linear_interp_core.sv]
// Wavetable of 1024 signed 16-bit samples with linear interpolation. One item
// is taken at a time: req_ready is high only while the core is idle, and a
// finished result waits in the rsp output register, so the next item can be
// taken while the previous result is still pending. An interpolate uses one
// multiplier twice and makes two reads from the single-port sample memory; a
// looped read runs the restoring remainder unit, which retires one index bit a
// cycle. A finished item waits in ST_DONE while a held result blocks the output
// register, and the core returns to idle once it has moved its result there.
// csr_wdata sets the number of samples in use (values above 1024 act as 1024);
// write it only while the core is idle. Samples must be written before read.
module wavetable_linear_interp_core
   import wtli_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [SIZE_BITS-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [SIZE_BITS-1:0]         csr_size_ff;
   req_type                      req_ff, req_in;
   logic [SIZE_BITS-1:0]         size_ff, size_in;
   logic [INDEX_BITS-1:0]        idx_ff, idx_in;
   logic [ADDR_BITS-1:0]         rem_ff, rem_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0]         addr_ff, addr_in;
   logic [ADDR_BITS-1:0]         i1_ff, i1_in;
   logic [PHASE_FRAC_BITS-1:0]   frac_ff, frac_in;
   logic signed [SAMPLE_BITS-1:0] v0_ff, v0_in;
   logic signed [DIFF_BITS-1:0]  diff_ff, diff_in;
   logic signed [PROD_BITS-1:0]  prod_ff;
   rsp_type                      res_ff, res_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;

   // shared multiplier operands
   logic                         mul_en;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;

   // sample memory
   logic signed [SAMPLE_BITS-1:0] mem [TABLE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rdata_ff;
   logic                          mem_we;
   logic                          mem_re;
   logic [ADDR_BITS-1:0]          mem_addr;

   logic                       req_take;
   logic                       out_free;
   logic [SIZE_BITS-1:0]       mod_trial;
   logic [ADDR_BITS-1:0]       i0;
   logic [SIZE_BITS-1:0]       i0_next;
   logic signed [DIFF_BITS-1:0] step;
   logic signed [DIFF_BITS-1:0] sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign mod_trial = {rem_ff, idx_ff[INDEX_BITS-1]};
   assign i0        = prod_ff[PHASE_FRAC_BITS +: ADDR_BITS];
   assign i0_next   = {1'b0, i0} + SIZE_BITS'(1);
   assign step      = prod_ff[PHASE_FRAC_BITS +: DIFF_BITS];
   assign sum       = DIFF_BITS'(v0_ff) + step;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (req_ff.func)
               FUNC_WRITE: state_in = ST_DONE;
               FUNC_READ: begin
                  state_in = ({{(INDEX_BITS-SIZE_BITS){1'b0}}, size_ff} > req_ff.index)
                             ? ST_RD : ST_DONE;
               end
               FUNC_LOOP: state_in = (size_ff != '0) ? ST_MOD : ST_DONE;
               FUNC_INTERP: begin
                  state_in = (size_ff != '0 && !req_ff.phase[PHASE_FRAC_BITS])
                             ? ST_MUL1 : ST_DONE;
               end
            endcase
         end
         ST_MOD: begin
            if (cnt_ff == CNT_BITS'(INDEX_BITS - 1)) state_in = ST_RD;
         end
         ST_RD:   state_in = ST_RDW;
         ST_RDW:  state_in = ST_DONE;
         ST_MUL1: state_in = ST_IDX;
         ST_IDX:  state_in = ST_RD0;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM:  state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      req_in       = req_ff;
      size_in      = size_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      i1_in        = i1_ff;
      frac_in      = frac_ff;
      v0_in        = v0_ff;
      diff_in      = diff_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = addr_ff;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in  = req_data;
               size_in = (csr_size_ff > SIZE_BITS'(TABLE_DEPTH))
                         ? SIZE_BITS'(TABLE_DEPTH) : csr_size_ff;
            end
         end
         ST_DECODE: begin
            res_in.value = '0;
            res_in.error = 1'b1;
            addr_in      = req_ff.index[ADDR_BITS-1:0];
            idx_in       = req_ff.index;
            rem_in       = '0;
            cnt_in       = '0;
            unique case (req_ff.func)
               FUNC_WRITE: begin
                  mem_addr = req_ff.index[ADDR_BITS-1:0];
                  if (req_ff.index[INDEX_BITS-1:ADDR_BITS] == '0) begin
                     mem_we       = 1'b1;
                     res_in.error = 1'b0;
                  end
               end
               FUNC_READ:   ;
               FUNC_LOOP:   ;
               FUNC_INTERP: ;
            endcase
         end
         ST_MOD: begin
            // restoring remainder, one index bit per cycle
            if (mod_trial >= size_ff) begin
               rem_in = ADDR_BITS'(mod_trial - size_ff);
            end else begin
               rem_in = mod_trial[ADDR_BITS-1:0];
            end
            idx_in  = idx_ff << 1;
            cnt_in  = cnt_ff + CNT_BITS'(1);
            addr_in = rem_in;
         end
         ST_RD: begin
            mem_re = 1'b1;
         end
         ST_RDW: begin
            res_in.value = rdata_ff;
            res_in.error = 1'b0;
         end
         ST_MUL1: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'({1'b0, req_ff.phase[PHASE_FRAC_BITS-1:0]});
            mul_b  = MUL_B_BITS'({1'b0, size_ff});
         end
         ST_IDX: begin
            addr_in = i0;
            frac_in = prod_ff[PHASE_FRAC_BITS-1:0];
            // last sample wraps to sample 0
            i1_in   = (i0_next == size_ff) ? '0 : i0_next[ADDR_BITS-1:0];
         end
         ST_RD0: begin
            mem_re = 1'b1;
         end
         ST_RD1: begin
            mem_re   = 1'b1;
            mem_addr = i1_ff;
            v0_in    = rdata_ff;
         end
         ST_DIFF: begin
            diff_in = DIFF_BITS'(rdata_ff) - DIFF_BITS'(v0_ff);
         end
         ST_MUL2: begin
            mul_en = 1'b1;
            mul_a  = MUL_A_BITS'({1'b0, frac_ff});
            mul_b  = MUL_B_BITS'(diff_ff);
         end
         ST_SUM: begin
            // arithmetic shift of the product floors toward minus infinity
            res_in.value = sum[SAMPLE_BITS-1:0];
            res_in.error = 1'b0;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_size_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) csr_size_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      size_ff <= size_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      addr_ff <= addr_in;
      i1_ff   <= i1_in;
      frac_ff <= frac_in;
      v0_ff   <= v0_in;
      diff_ff <= diff_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      if (mul_en) prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= req_ff.sample_in;
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

endmodule

[sv/wtli_checker.sv]
module wtli_checker
   import wtli_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_type              rsp_data
);

   // a pending result holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // an error result always carries a zero value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_data.error || rsp_data.value == '0)
      else $error("error item with nonzero value");

   // one item in flight: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous one still in flight");

   // no result can appear in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result delivered too early");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

endmodule

bind wavetable_linear_interp_core wtli_checker u_wtli_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
